// ===== sv/afr_pkg.sv =====
// afr_pkg: shared constants, codes and types for the audio frame reorder/repair block.
// No dependencies; used by every module in sv/.
`timescale 1ns / 1ps

package afr_pkg;

	localparam int unsigned MAX_BACKLOG = 16;
	localparam int unsigned MAX_MISSED  = 32;
	localparam int unsigned RES_CAP     = 32;

	localparam int unsigned CNT_W  = $clog2(MAX_BACKLOG + 1);
	localparam int unsigned IDX_W  = (MAX_BACKLOG > 1) ? $clog2(MAX_BACKLOG) : 1;
	localparam int unsigned MISS_W = $clog2(MAX_MISSED + 1);
	localparam int unsigned RES_W  = $clog2(RES_CAP + 1);

	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned LAT_W    = 32;
	localparam int unsigned ML_W     = 32;
	localparam int unsigned SR_W     = 19;
	localparam int unsigned CFG_W    = 16;

	// ml * 1000 / (48000 * 256) reduces to (ml >> 12) / 3,
	// ml * 1000 / (44100 * 256) reduces to ((ml * 5) >> 7) / 441
	localparam int unsigned LAT48_SHIFT = 12;
	localparam int unsigned LAT44_SHIFT = 7;

	// constant divider by reciprocal multiplication
	localparam int unsigned QDIV_W      = 28;
	localparam int unsigned DREM_W      = 9;
	localparam int unsigned RECIP_W     = 31;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned PROD_W      = QDIV_W + RECIP_W;

	localparam logic [DREM_W-1:0]  DIV_3           = DREM_W'(3);
	localparam logic [DREM_W-1:0]  RATE_FAMILY_DIV = DREM_W'(441);
	localparam logic [RECIP_W-1:0] RECIP_3         = RECIP_W'(64'h1_0000_0000 / 64'd3);
	localparam logic [RECIP_W-1:0] RECIP_441       = RECIP_W'(64'h1_0000_0000 / 64'd441);
	localparam logic [CFG_W-1:0]   DEF_LAT_RESET   = CFG_W'(100);

	typedef enum logic [1:0] {
		ACT_DELIVER = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_RESEND  = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		BL_NOP,
		BL_INS,
		BL_POP,
		BL_CLR
	} bl_op_t;

	typedef struct packed {
		bl_op_t              op;
		logic [CNT_W-1:0]    pos;
		logic [FRAME_W-1:0]  frame;
		logic [HANDLE_W-1:0] handle;
	} bl_cmd_t;

	typedef struct packed {
		act_t                action;
		logic [FRAME_W-1:0]  frame;
		logic [HANDLE_W-1:0] handle;
		logic [LAT_W-1:0]    latency;
		logic                stream_start;
		logic                stream_lost;
	} res_t;

endpackage

// ===== sv/audio_frame_reorder_repair.sv =====
// Frame reorder buffer with resend requests: sequencer around a shared 32-bit
// comparator, the constant latency divider and the sorted backlog.
// Depends on afr_pkg, afr_div and afr_backlog.
`timescale 1ns / 1ps

// An item is taken when start is high and busy low; busy drops in the same cycle
// as the final result of that item shows. Results appear at most one per cycle on the
// result ports with result_strobe high for exactly one cycle, and the receiver
// cannot stall them; last marks the final result of an item. A frame item
// compares against the last frame sent, the first waiting frame and the newest
// backlogged frame, may scan up to 16 backlog entries and drains frames that
// have come into order. A backlog overflow releases every waiting frame. A repair
// tick sends resend requests for the missing ranges that it examines; a tick
// outside a repair is taken without raising busy. The first frame of a stream
// with non-zero media latency runs the constant divider twice.
module audio_frame_reorder_repair (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [afr_pkg::FRAME_W-1:0]   frame_number,
	input  logic [afr_pkg::HANDLE_W-1:0]  buffer_handle,
	input  logic [afr_pkg::ML_W-1:0]      media_latency,
	input  logic [afr_pkg::SR_W-1:0]      sample_rate,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afr_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_strobe,
	output logic [1:0]                    action,
	output logic [afr_pkg::FRAME_W-1:0]   out_frame,
	output logic [afr_pkg::HANDLE_W-1:0]  out_handle,
	output logic [afr_pkg::LAT_W-1:0]     latency_ms,
	output logic                          stream_start,
	output logic                          stream_lost,
	output logic                          last
);

	typedef enum logic [3:0] {
		S_IDLE, S_LMOD, S_LMOD_W, S_LDIV, S_LDIV_W, S_CMP_LAST, S_CMP_FW, S_CMP_NEW,
		S_SCAN, S_DRAIN, S_OVF_FW, S_OVF_BL, S_OVF_FR, S_TK_SET, S_TK_RUN, S_FIN
	} state_t;

	state_t                        state_q;
	logic [afr_pkg::CFG_W-1:0]     def_lat_q;
	logic [afr_pkg::FRAME_W-1:0]   fr_q;
	logic [afr_pkg::HANDLE_W-1:0]  h_q;
	logic [afr_pkg::ML_W-1:0]      ml_q;
	logic [afr_pkg::SR_W-1:0]      sr_q;
	logic                          started_q;
	logic                          repairing_q;
	logic [afr_pkg::FRAME_W-1:0]   last_sent_q;
	logic [afr_pkg::FRAME_W-1:0]   fw_q;
	logic [afr_pkg::HANDLE_W-1:0]  fwh_q;
	logic [afr_pkg::FRAME_W-1:0]   newest_q;
	logic [afr_pkg::CNT_W-1:0]     idx_q;
	logic                          tk_first_q;
	logic [afr_pkg::FRAME_W-1:0]   prev_q;
	logic [afr_pkg::FRAME_W-1:0]   cur_q;
	logic [afr_pkg::FRAME_W-1:0]   bnd_q;
	logic [afr_pkg::MISS_W-1:0]    cnt_q;
	logic [afr_pkg::RES_W-1:0]     res_n_q;
	afr_pkg::res_t                 pend_q;
	logic                          pend_v_q;
	afr_pkg::res_t                 out_q;
	logic                          strobe_q;
	logic                          last_q;

	afr_pkg::bl_cmd_t              bl_cmd;
	logic [afr_pkg::FRAME_W-1:0]   rd_frame;
	logic [afr_pkg::HANDLE_W-1:0]  rd_handle;
	logic [afr_pkg::FRAME_W-1:0]   front_frame;
	logic [afr_pkg::HANDLE_W-1:0]  front_handle;
	logic [afr_pkg::CNT_W-1:0]     bl_count;

	logic                          div_go;
	logic                          div_sel;
	logic [afr_pkg::QDIV_W-1:0]    div_dvd;
	logic                          div_done;
	logic [afr_pkg::QDIV_W-1:0]    div_quo;
	logic [afr_pkg::DREM_W-1:0]    div_rem;
	logic [afr_pkg::ML_W+2:0]      ml_x5;

	logic [afr_pkg::FRAME_W-1:0]   sub_a;
	logic [afr_pkg::FRAME_W-1:0]   sub_b;
	logic [afr_pkg::FRAME_W-1:0]   diff;
	logic [afr_pkg::FRAME_W-1:0]   bound;
	logic [afr_pkg::FRAME_W-1:0]   prev_inc;
	logic                          d_one;
	logic                          d_zero;
	logic                          d_neg;
	logic                          d_pos;
	logic                          full;
	logic                          idx_last;
	logic                          tk_done;
	logic                          push_en;
	logic                          push_ok;
	afr_pkg::res_t                 push_res;

	afr_backlog u_backlog (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (bl_cmd),
		.rd_idx       (idx_q[afr_pkg::IDX_W-1:0]),
		.rd_frame     (rd_frame),
		.rd_handle    (rd_handle),
		.front_frame  (front_frame),
		.front_handle (front_handle),
		.count        (bl_count)
	);

	afr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.sel_441   (div_sel),
		.dividend  (div_dvd),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// shared modulo-2^32 comparator
	assign bound    = tk_first_q ? fw_q : rd_frame;
	assign prev_inc = prev_q + afr_pkg::FRAME_W'(1);

	always_comb begin
		sub_a = fr_q;
		case (state_q)
			S_TK_SET:   begin sub_a = bound; sub_b = prev_inc;    end
			S_CMP_LAST: sub_b = last_sent_q;
			S_CMP_FW:   sub_b = fw_q;
			S_CMP_NEW:  sub_b = newest_q;
			default:    sub_b = rd_frame;
		endcase
	end

	assign diff     = sub_a - sub_b;
	assign d_one    = diff == afr_pkg::FRAME_W'(1);
	assign d_zero   = diff == '0;
	assign d_neg    = diff[afr_pkg::FRAME_W-1];
	assign d_pos    = !d_neg && !d_zero;
	assign full     = bl_count == afr_pkg::CNT_W'(afr_pkg::MAX_BACKLOG);
	assign idx_last = (idx_q + afr_pkg::CNT_W'(1)) == bl_count;
	assign tk_done  = (!tk_first_q && idx_q >= bl_count)
	               || (cnt_q >= afr_pkg::MISS_W'(afr_pkg::MAX_MISSED));

	// divider operands: first sample_rate mod 441, then the latency quotient
	assign ml_x5   = afr_pkg::ML_W'(0) + (afr_pkg::ML_W+3)'({ml_q, 2'b00})
	               + (afr_pkg::ML_W+3)'(ml_q);
	assign div_sel = (state_q == S_LMOD) || (div_rem == '0);
	assign div_dvd = (state_q == S_LMOD) ? afr_pkg::QDIV_W'(sr_q)
	               : ((div_rem == '0)
	                  ? ml_x5[afr_pkg::ML_W+2:afr_pkg::LAT44_SHIFT]
	                  : afr_pkg::QDIV_W'(ml_q[afr_pkg::ML_W-1:afr_pkg::LAT48_SHIFT]));
	assign div_go  = (state_q == S_LMOD && ml_q != '0) || state_q == S_LDIV;

	always_comb begin
		push_en  = 1'b0;
		push_res = '0;
		bl_cmd   = '0;
		push_res.action = afr_pkg::ACT_RELEASE;
		push_res.frame  = fr_q;
		push_res.handle = h_q;
		case (state_q)
			S_LMOD: begin
				if (ml_q == '0) begin
					push_en = 1'b1;
					push_res.action       = afr_pkg::ACT_DELIVER;
					push_res.latency      = afr_pkg::LAT_W'(def_lat_q);
					push_res.stream_start = 1'b1;
				end
			end
			S_LDIV_W: begin
				if (div_done) begin
					push_en = 1'b1;
					push_res.action       = afr_pkg::ACT_DELIVER;
					push_res.latency      = afr_pkg::LAT_W'(div_quo);
					push_res.stream_start = 1'b1;
				end
			end
			S_CMP_LAST: begin
				if (d_one) begin
					push_en = 1'b1;
					push_res.action = afr_pkg::ACT_DELIVER;
				end else if (!d_pos) begin
					push_en = 1'b1;
				end
			end
			S_CMP_FW: begin
				if (d_neg) begin
					if (!full) begin
						bl_cmd.op     = afr_pkg::BL_INS;
						bl_cmd.frame  = fw_q;
						bl_cmd.handle = fwh_q;
					end
				end else if (d_zero) begin
					push_en = 1'b1;
				end else if (bl_count == '0) begin
					bl_cmd.op     = afr_pkg::BL_INS;
					bl_cmd.frame  = fr_q;
					bl_cmd.handle = h_q;
				end
			end
			S_CMP_NEW: begin
				if (d_pos) begin
					if (!full) begin
						bl_cmd.op     = afr_pkg::BL_INS;
						bl_cmd.pos    = bl_count;
						bl_cmd.frame  = fr_q;
						bl_cmd.handle = h_q;
					end
				end else if (d_zero) begin
					push_en = 1'b1;
				end
			end
			S_SCAN: begin
				if (d_neg) begin
					if (!full) begin
						bl_cmd.op     = afr_pkg::BL_INS;
						bl_cmd.pos    = idx_q;
						bl_cmd.frame  = fr_q;
						bl_cmd.handle = h_q;
					end
				end else if (d_zero || idx_last) begin
					push_en = 1'b1;
				end
			end
			S_DRAIN: begin
				push_en = 1'b1;
				push_res.action = afr_pkg::ACT_DELIVER;
				push_res.frame  = fw_q;
				push_res.handle = fwh_q;
				if (bl_count != '0)
					bl_cmd.op = afr_pkg::BL_POP;
			end
			S_OVF_FW: begin
				push_en = 1'b1;
				push_res.frame       = fw_q;
				push_res.handle      = fwh_q;
				push_res.stream_lost = 1'b1;
			end
			S_OVF_BL: begin
				push_en = 1'b1;
				push_res.frame       = rd_frame;
				push_res.handle      = rd_handle;
				push_res.stream_lost = 1'b1;
			end
			S_OVF_FR: begin
				push_en = 1'b1;
				push_res.stream_lost = 1'b1;
				bl_cmd.op = afr_pkg::BL_CLR;
			end
			S_TK_RUN: begin
				push_en = 1'b1;
				push_res.action = afr_pkg::ACT_RESEND;
				push_res.frame  = cur_q;
				push_res.handle = '0;
			end
			default: ;
		endcase
	end

	// results beyond the per-item cap are dropped
	assign push_ok = push_en && (res_n_q < afr_pkg::RES_W'(afr_pkg::RES_CAP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			def_lat_q   <= afr_pkg::DEF_LAT_RESET;
			fr_q        <= '0;
			h_q         <= '0;
			ml_q        <= '0;
			sr_q        <= '0;
			started_q   <= 1'b0;
			repairing_q <= 1'b0;
			last_sent_q <= '0;
			fw_q        <= '0;
			fwh_q       <= '0;
			newest_q    <= '0;
			idx_q       <= '0;
			tk_first_q  <= 1'b0;
			prev_q      <= '0;
			cur_q       <= '0;
			bnd_q       <= '0;
			cnt_q       <= '0;
			res_n_q     <= '0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			out_q       <= '0;
			strobe_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid)
				def_lat_q <= cfg_data;

			// one result held back so that the final one can carry last
			if (push_ok) begin
				if (pend_v_q) begin
					out_q    <= pend_q;
					last_q   <= 1'b0;
					strobe_q <= 1'b1;
				end
				pend_q   <= push_res;
				pend_v_q <= 1'b1;
				res_n_q  <= res_n_q + afr_pkg::RES_W'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						fr_q    <= frame_number;
						h_q     <= buffer_handle;
						ml_q    <= media_latency;
						sr_q    <= sample_rate;
						res_n_q <= '0;
						if (op) begin
							if (repairing_q) begin
								tk_first_q <= 1'b1;
								prev_q     <= last_sent_q;
								cnt_q      <= '0;
								idx_q      <= '0;
								state_q    <= S_TK_SET;
							end
						end else if (!started_q) begin
							state_q <= S_LMOD;
						end else begin
							state_q <= S_CMP_LAST;
						end
					end
				end
				S_LMOD: begin
					if (ml_q == '0) begin
						started_q   <= 1'b1;
						last_sent_q <= fr_q;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_LMOD_W;
					end
				end
				S_LMOD_W: begin
					if (div_done)
						state_q <= S_LDIV;
				end
				S_LDIV: state_q <= S_LDIV_W;
				S_LDIV_W: begin
					if (div_done) begin
						started_q   <= 1'b1;
						last_sent_q <= fr_q;
						state_q     <= S_FIN;
					end
				end
				S_CMP_LAST: begin
					if (d_one) begin
						last_sent_q <= fr_q;
						state_q <= (repairing_q && fw_q == fr_q + afr_pkg::FRAME_W'(1))
						           ? S_DRAIN : S_FIN;
					end else if (!d_pos) begin
						state_q <= S_FIN;
					end else if (!repairing_q) begin
						repairing_q <= 1'b1;
						fw_q        <= fr_q;
						fwh_q       <= h_q;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_CMP_FW;
					end
				end
				S_CMP_FW: begin
					if (d_neg) begin
						if (full) begin
							state_q <= S_OVF_FW;
						end else begin
							if (bl_count == '0)
								newest_q <= fw_q;
							fw_q    <= fr_q;
							fwh_q   <= h_q;
							state_q <= S_FIN;
						end
					end else if (d_zero) begin
						state_q <= S_FIN;
					end else if (bl_count == '0) begin
						newest_q <= fr_q;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_CMP_NEW;
					end
				end
				S_CMP_NEW: begin
					if (d_pos) begin
						if (full) begin
							state_q <= S_OVF_FW;
						end else begin
							newest_q <= fr_q;
							state_q  <= S_FIN;
						end
					end else if (d_zero) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (d_neg) begin
						state_q <= full ? S_OVF_FW : S_FIN;
					end else if (d_zero || idx_last) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + afr_pkg::CNT_W'(1);
					end
				end
				S_DRAIN: begin
					last_sent_q <= fw_q;
					if (bl_count == '0) begin
						repairing_q <= 1'b0;
						state_q     <= S_FIN;
					end else begin
						fw_q  <= front_frame;
						fwh_q <= front_handle;
						if (front_frame != fw_q + afr_pkg::FRAME_W'(1))
							state_q <= S_FIN;
					end
				end
				S_OVF_FW: begin
					idx_q   <= '0;
					state_q <= (bl_count == '0) ? S_OVF_FR : S_OVF_BL;
				end
				S_OVF_BL: begin
					if (idx_last)
						state_q <= S_OVF_FR;
					else
						idx_q <= idx_q + afr_pkg::CNT_W'(1);
				end
				S_OVF_FR: begin
					repairing_q <= 1'b0;
					started_q   <= 1'b0;
					state_q     <= S_FIN;
				end
				S_TK_SET: begin
					if (tk_done) begin
						state_q <= S_FIN;
					end else if (d_pos) begin
						cur_q   <= prev_inc;
						bnd_q   <= bound;
						state_q <= S_TK_RUN;
					end else begin
						prev_q <= bound;
						if (tk_first_q)
							tk_first_q <= 1'b0;
						else
							idx_q <= idx_q + afr_pkg::CNT_W'(1);
					end
				end
				S_TK_RUN: begin
					cnt_q <= cnt_q + afr_pkg::MISS_W'(1);
					cur_q <= cur_q + afr_pkg::FRAME_W'(1);
					if (cur_q + afr_pkg::FRAME_W'(1) == bnd_q
					    || cnt_q + afr_pkg::MISS_W'(1) == afr_pkg::MISS_W'(afr_pkg::MAX_MISSED)) begin
						prev_q <= bnd_q;
						if (tk_first_q)
							tk_first_q <= 1'b0;
						else
							idx_q <= idx_q + afr_pkg::CNT_W'(1);
						state_q <= S_TK_SET;
					end
				end
				S_FIN: begin
					if (pend_v_q) begin
						out_q    <= pend_q;
						last_q   <= 1'b1;
						strobe_q <= 1'b1;
						pend_v_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign action        = out_q.action;
	assign out_frame     = out_q.frame;
	assign out_handle    = out_q.handle;
	assign latency_ms    = out_q.latency;
	assign stream_start  = out_q.stream_start;
	assign stream_lost   = out_q.stream_lost;
	assign last          = last_q;

endmodule

// ===== sv/afr_div.sv =====
// afr_div: divider by the constant 3 or 441 using reciprocal multiplication and
// one correction step, in reciprocal, back-multiply and fix steps on a single shared multiplier.
// Depends on afr_pkg for widths and constants.
`timescale 1ns / 1ps

module afr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic                        sel_441,
	input  logic [afr_pkg::QDIV_W-1:0]  dividend,
	output logic                        done,
	output logic [afr_pkg::QDIV_W-1:0]  quotient,
	output logic [afr_pkg::DREM_W-1:0]  remainder
);

	typedef enum logic [1:0] {
		P_IDLE, P_RECIP, P_BACK, P_FIX
	} phase_t;

	phase_t                      phase_q;
	logic [afr_pkg::QDIV_W-1:0]  x_q;
	logic                        sel_q;
	logic [afr_pkg::PROD_W-1:0]  prod_q;
	logic [afr_pkg::QDIV_W-1:0]  quo_q;
	logic [afr_pkg::DREM_W-1:0]  rem_q;
	logic                        done_q;

	logic [afr_pkg::DREM_W-1:0]  dvs;
	logic [afr_pkg::QDIV_W-1:0]  q0;
	logic [afr_pkg::QDIV_W-1:0]  mul_a;
	logic [afr_pkg::RECIP_W-1:0] mul_b;
	logic [afr_pkg::PROD_W-1:0]  mul_p;
	logic [afr_pkg::QDIV_W-1:0]  r_full;
	logic [afr_pkg::DREM_W:0]    r0;
	logic                        r_over;

	assign dvs = sel_q ? afr_pkg::RATE_FAMILY_DIV : afr_pkg::DIV_3;
	// estimate is the true quotient or one below it
	assign q0  = afr_pkg::QDIV_W'(prod_q[afr_pkg::PROD_W-1:afr_pkg::RECIP_SHIFT]);

	assign mul_a = (phase_q == P_BACK) ? q0 : x_q;
	assign mul_b = (phase_q == P_BACK) ? afr_pkg::RECIP_W'(dvs)
	             : (sel_q ? afr_pkg::RECIP_441 : afr_pkg::RECIP_3);
	assign mul_p = afr_pkg::PROD_W'(mul_a) * afr_pkg::PROD_W'(mul_b);

	assign r_full = x_q - prod_q[afr_pkg::QDIV_W-1:0];
	assign r0     = r_full[afr_pkg::DREM_W:0];
	assign r_over = r0 >= {1'b0, dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			x_q     <= '0;
			sel_q   <= 1'b0;
			prod_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (phase_q)
				P_IDLE: begin
					done_q <= 1'b0;
					if (go) begin
						x_q     <= dividend;
						sel_q   <= sel_441;
						phase_q <= P_RECIP;
					end
				end
				P_RECIP: begin
					prod_q  <= mul_p;
					phase_q <= P_BACK;
				end
				P_BACK: begin
					quo_q   <= q0;
					prod_q  <= mul_p;
					phase_q <= P_FIX;
				end
				P_FIX: begin
					if (r_over) begin
						quo_q <= quo_q + afr_pkg::QDIV_W'(1);
						rem_q <= afr_pkg::DREM_W'(r0 - {1'b0, dvs});
					end else begin
						rem_q <= r0[afr_pkg::DREM_W-1:0];
					end
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== sv/afr_backlog.sv =====
// afr_backlog: sorted backlog of waiting frames with insert, pop-front and clear.
// Depends on afr_pkg for the command type and sizes.
`timescale 1ns / 1ps

module afr_backlog (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afr_pkg::bl_cmd_t              cmd,
	input  logic [afr_pkg::IDX_W-1:0]     rd_idx,
	output logic [afr_pkg::FRAME_W-1:0]   rd_frame,
	output logic [afr_pkg::HANDLE_W-1:0]  rd_handle,
	output logic [afr_pkg::FRAME_W-1:0]   front_frame,
	output logic [afr_pkg::HANDLE_W-1:0]  front_handle,
	output logic [afr_pkg::CNT_W-1:0]     count
);

	logic [afr_pkg::FRAME_W-1:0]  frames_q  [afr_pkg::MAX_BACKLOG];
	logic [afr_pkg::HANDLE_W-1:0] handles_q [afr_pkg::MAX_BACKLOG];
	logic [afr_pkg::CNT_W-1:0]    count_q;

	for (genvar k = 0; k < afr_pkg::MAX_BACKLOG; k++) begin : g_ent
		localparam int PREV = (k > 0) ? k - 1 : 0;
		localparam int NEXT = (k < afr_pkg::MAX_BACKLOG - 1) ? k + 1 : k;
		always_ff @(posedge clk) begin
			case (cmd.op)
				afr_pkg::BL_INS: begin
					if (cmd.pos == afr_pkg::CNT_W'(k)) begin
						frames_q[k]  <= cmd.frame;
						handles_q[k] <= cmd.handle;
					end else if (cmd.pos < afr_pkg::CNT_W'(k)) begin
						frames_q[k]  <= frames_q[PREV];
						handles_q[k] <= handles_q[PREV];
					end
				end
				afr_pkg::BL_POP: begin
					frames_q[k]  <= frames_q[NEXT];
					handles_q[k] <= handles_q[NEXT];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				afr_pkg::BL_INS: count_q <= count_q + afr_pkg::CNT_W'(1);
				afr_pkg::BL_POP: count_q <= count_q - afr_pkg::CNT_W'(1);
				afr_pkg::BL_CLR: count_q <= '0;
				default: ;
			endcase
		end
	end

	assign rd_frame     = frames_q[rd_idx];
	assign rd_handle    = handles_q[rd_idx];
	assign front_frame  = frames_q[0];
	assign front_handle = handles_q[0];
	assign count        = count_q;

endmodule
